FILE: rtl/sqsc_pkg.sv
// ----------------------------------------------------------------------------
// sqsc_pkg
// shared types, constants and helpers for the sprite quad setup and cull block
// ----------------------------------------------------------------------------
package sqsc_pkg;

    // corner coordinates are kept exactly in Q.35, with the rounding half folded in
    localparam int CW       = 62;
    localparam int Q8_SHIFT = 27;

    typedef logic signed [CW-1:0] corner_t;

    localparam corner_t ROUND_HALF = corner_t'(64'sd67108864);

    localparam logic signed [CW-Q8_SHIFT-1:0] SAT_HI = 8388607;
    localparam logic signed [CW-Q8_SHIFT-1:0] SAT_LO = -8388608;

    localparam logic [15:0] TEX_ONE   = 16'd32768;
    localparam logic [15:0] CLIP_ONE  = 16'd32768;

    // register reset values
    localparam logic [15:0]        ZOOM_RESET   = 16'd256;
    localparam logic signed [15:0] LEFT_RESET   = -16'sd960;
    localparam logic signed [15:0] TOP_RESET    = -16'sd540;
    localparam logic signed [15:0] RIGHT_RESET  = 16'sd960;
    localparam logic signed [15:0] BOTTOM_RESET = 16'sd540;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_ZOOM   = 3'd0;
    localparam logic [2:0] REG_LEFT   = 3'd1;
    localparam logic [2:0] REG_TOP    = 3'd2;
    localparam logic [2:0] REG_RIGHT  = 3'd3;
    localparam logic [2:0] REG_BOTTOM = 3'd4;

    // vertex slots of one sprite strip
    localparam logic [2:0] SLOT_TL0 = 3'd0;
    localparam logic [2:0] SLOT_TL1 = 3'd1;
    localparam logic [2:0] SLOT_TR  = 3'd2;
    localparam logic [2:0] SLOT_BL  = 3'd3;
    localparam logic [2:0] SLOT_BR0 = 3'd4;
    localparam logic [2:0] SLOT_BR1 = 3'd5;

    typedef struct packed {
        logic               is_drawable;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic [11:0]        sprite_width;
        logic [11:0]        sprite_height;
        logic [15:0]        clip;
        logic [7:0]         alpha;
        logic [23:0]        frame;
    } sprite_t;

    typedef struct packed {
        logic signed [23:0] vertex_x;
        logic signed [23:0] vertex_y;
        logic               tex_s;
        logic [15:0]        tex_t;
        logic [23:0]        vertex_frame;
        logic [7:0]         vertex_alpha;
        logic               last;
    } vertex_t;

    // drop the fraction below Q.8 and saturate to 24 bits
    function automatic logic signed [23:0] sat_q8(input corner_t v);
        logic signed [CW-Q8_SHIFT-1:0] r;
        r = v[CW-1:Q8_SHIFT];
        if (r > SAT_HI)
            return SAT_HI[23:0];
        else if (r < SAT_LO)
            return SAT_LO[23:0];
        else
            return r[23:0];
    endfunction

endpackage

FILE: rtl/sprite_quad_setup_with_cull_unit.sv
// ----------------------------------------------------------------------------
// sprite_quad_setup_with_cull_unit
// rotated sprite quad setup with bounding-box cull, six strip vertices per sprite
// ----------------------------------------------------------------------------
// channel  dir  handshake                    payload
// sprite   in   sprite_valid / sprite_ready  sqsc_pkg::sprite_t
// vertex   out  vertex_valid / vertex_ready  sqsc_pkg::vertex_t
// apb      in   psel penable pwrite / pready zoom and screen bounds
//
// five pipeline stages, then a vertex expander and the output register
// a sprite passes stages 1 to 5 and the expander before its first vertex is registered
// a drawn sprite gives six vertices: the expander sends one a cycle while the output is not stalled
// culled or non-drawable sprites give no vertex
// reset clears the valid bits and loads the register defaults
// an output stall backs up stage by stage through the ready chain
// ----------------------------------------------------------------------------
module sprite_quad_setup_with_cull_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sprite_valid,
    output logic              sprite_ready,
    input  sqsc_pkg::sprite_t sprite,
    output logic              vertex_valid,
    input  logic              vertex_ready,
    output sqsc_pkg::vertex_t vertex,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import sqsc_pkg::*;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic [11:0]        w;
        logic [11:0]        h;
        logic [15:0]        clip;
        logic [7:0]         alpha;
        logic [23:0]        frame;
    } st1_t;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [11:0]        w;
        logic [11:0]        h;
        logic signed [27:0] axh;
        logic signed [27:0] ayw;
        logic signed [27:0] axw;
        logic signed [27:0] ayh;
        logic signed [31:0] uzx;
        logic signed [31:0] uzy;
        logic [26:0]        hc;
        logic [15:0]        tclip;
        logic [7:0]         alpha;
        logic [23:0]        frame;
    } st2_t;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [27:0]        sbx;
        logic [27:0]        sby;
        logic signed [43:0] uzyw;
        logic signed [43:0] uzxw;
        logic signed [43:0] uzxh;
        logic signed [43:0] uzyh;
        logic signed [58:0] bhx;
        logic signed [58:0] bhy;
        logic [15:0]        tclip;
        logic [7:0]         alpha;
        logic [23:0]        frame;
    } st3_t;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [43:0]        sx;
        logic [43:0]        sy;
        corner_t            tl_x;
        corner_t            tl_y;
        corner_t            dw_x;
        corner_t            dw_y;
        corner_t            dh_x;
        corner_t            dh_y;
        logic [15:0]        tclip;
        logic [7:0]         alpha;
        logic [23:0]        frame;
    } st4_t;

    typedef struct packed {
        corner_t     tl_x;
        corner_t     tl_y;
        corner_t     tr_x;
        corner_t     tr_y;
        corner_t     bl_x;
        corner_t     bl_y;
        corner_t     dw_x;
        corner_t     dw_y;
        logic [15:0] tclip;
        logic [7:0]  alpha;
        logic [23:0] frame;
    } st5_t;

    typedef struct packed {
        corner_t     tl_x;
        corner_t     tl_y;
        corner_t     tr_x;
        corner_t     tr_y;
        corner_t     bl_x;
        corner_t     bl_y;
        corner_t     br_x;
        corner_t     br_y;
        logic [15:0] tclip;
        logic [7:0]  alpha;
        logic [23:0] frame;
    } st6_t;

    // configuration registers
    logic [15:0]        zoom_reg;
    logic signed [15:0] screen_left_reg;
    logic signed [15:0] screen_top_reg;
    logic signed [15:0] screen_right_reg;
    logic signed [15:0] screen_bottom_reg;
    logic               cfg_write;
    logic [2:0]         cfg_index;

    // pipeline
    logic    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, ev_reg, ov_reg;
    logic    rdy1, rdy2, rdy3, rdy4, rdy5, e_ready;
    st1_t    s1_reg, s1_next;
    st2_t    s2_reg, s2_next;
    st3_t    s3_reg, s3_next;
    st4_t    s4_reg, s4_next;
    st5_t    s5_reg, s5_next;
    st6_t    s6_reg, s6_next;
    logic    culled;
    logic [2:0] cnt_reg, cnt_next;
    logic    out_load, emit, e_done;
    vertex_t vertex_reg, vertex_next;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg          <= ZOOM_RESET;
            screen_left_reg   <= LEFT_RESET;
            screen_top_reg    <= TOP_RESET;
            screen_right_reg  <= RIGHT_RESET;
            screen_bottom_reg <= BOTTOM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ZOOM:   zoom_reg          <= pwdata[15:0];
                REG_LEFT:   screen_left_reg   <= pwdata[15:0];
                REG_TOP:    screen_top_reg    <= pwdata[15:0];
                REG_RIGHT:  screen_right_reg  <= pwdata[15:0];
                REG_BOTTOM: screen_bottom_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_ZOOM:   prdata = {16'd0, zoom_reg};
            REG_LEFT:   prdata = {16'd0, screen_left_reg};
            REG_TOP:    prdata = {16'd0, screen_top_reg};
            REG_RIGHT:  prdata = {16'd0, screen_right_reg};
            REG_BOTTOM: prdata = {16'd0, screen_bottom_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    assign out_load     = !ov_reg || vertex_ready;
    assign emit         = ev_reg && out_load;
    assign e_done       = emit && (cnt_reg == SLOT_BR1);
    assign e_ready      = !ev_reg || e_done;
    assign rdy5         = !v5_reg || e_ready;
    assign rdy4         = !v4_reg || rdy5;
    assign rdy3         = !v3_reg || rdy4;
    assign rdy2         = !v2_reg || rdy3;
    assign rdy1         = !v1_reg || rdy2;
    assign sprite_ready = rdy1;

    always_comb
    begin
        if (emit)
            cnt_next = (cnt_reg == SLOT_BR1) ? SLOT_TL0 : cnt_reg + 3'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            ev_reg  <= 1'b0;
            ov_reg  <= 1'b0;
            cnt_reg <= SLOT_TL0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= sprite_valid && sprite.is_drawable;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg && !culled;
            if (e_ready)
                ev_reg <= v5_reg;
            if (out_load)
                ov_reg <= ev_reg;
            cnt_reg <= cnt_next;
        end
    end

    // ---------------- stage 1: capture, clamp clip ----------------
    always_comb
    begin
        s1_next.px    = sprite.pos_x;
        s1_next.py    = sprite.pos_y;
        s1_next.ux    = sprite.unit_x;
        s1_next.uy    = sprite.unit_y;
        s1_next.w     = sprite.sprite_width;
        s1_next.h     = sprite.sprite_height;
        s1_next.clip  = (sprite.clip > CLIP_ONE) ? CLIP_ONE : sprite.clip;
        s1_next.alpha = sprite.alpha;
        s1_next.frame = sprite.frame;
    end

    // ---------------- stage 2: narrow products ----------------
    always_comb
    begin
        logic signed [28:0] p_axh, p_ayw, p_axw, p_ayh;
        logic signed [32:0] p_uzx, p_uzy;
        logic [27:0]        p_hc;
        p_axh = s1_reg.ux * $signed({1'b0, s1_reg.h});
        p_ayw = s1_reg.uy * $signed({1'b0, s1_reg.w});
        p_axw = s1_reg.ux * $signed({1'b0, s1_reg.w});
        p_ayh = s1_reg.uy * $signed({1'b0, s1_reg.h});
        p_uzx = s1_reg.ux * $signed({1'b0, zoom_reg});
        p_uzy = s1_reg.uy * $signed({1'b0, zoom_reg});
        p_hc  = s1_reg.h * s1_reg.clip;

        s2_next.px    = s1_reg.px;
        s2_next.py    = s1_reg.py;
        s2_next.w     = s1_reg.w;
        s2_next.h     = s1_reg.h;
        s2_next.axh   = p_axh[27:0];
        s2_next.ayw   = p_ayw[27:0];
        s2_next.axw   = p_axw[27:0];
        s2_next.ayh   = p_ayh[27:0];
        s2_next.uzx   = p_uzx[31:0];
        s2_next.uzy   = p_uzy[31:0];
        s2_next.hc    = p_hc[26:0];
        s2_next.tclip = TEX_ONE - s1_reg.clip;
        s2_next.alpha = s1_reg.alpha;
        s2_next.frame = s1_reg.frame;
    end

    // ---------------- stage 3: extents and edge vectors ----------------
    always_comb
    begin
        logic [26:0]        m_axh, m_ayw, m_axw, m_ayh;
        logic signed [44:0] p_uzyw, p_uzxw, p_uzxh, p_uzyh;
        logic signed [59:0] p_bhx, p_bhy;
        m_axh  = s2_reg.axh[27] ? 27'(-s2_reg.axh) : s2_reg.axh[26:0];
        m_ayw  = s2_reg.ayw[27] ? 27'(-s2_reg.ayw) : s2_reg.ayw[26:0];
        m_axw  = s2_reg.axw[27] ? 27'(-s2_reg.axw) : s2_reg.axw[26:0];
        m_ayh  = s2_reg.ayh[27] ? 27'(-s2_reg.ayh) : s2_reg.ayh[26:0];
        p_uzyw = s2_reg.uzy * $signed({1'b0, s2_reg.w});
        p_uzxw = s2_reg.uzx * $signed({1'b0, s2_reg.w});
        p_uzxh = s2_reg.uzx * $signed({1'b0, s2_reg.h});
        p_uzyh = s2_reg.uzy * $signed({1'b0, s2_reg.h});
        p_bhx  = s2_reg.uzx * $signed({1'b0, s2_reg.hc});
        p_bhy  = s2_reg.uzy * $signed({1'b0, s2_reg.hc});

        s3_next.px    = s2_reg.px;
        s3_next.py    = s2_reg.py;
        s3_next.sbx   = {1'b0, m_axh} + {1'b0, m_ayw};
        s3_next.sby   = {1'b0, m_axw} + {1'b0, m_ayh};
        s3_next.uzyw  = p_uzyw[43:0];
        s3_next.uzxw  = p_uzxw[43:0];
        s3_next.uzxh  = p_uzxh[43:0];
        s3_next.uzyh  = p_uzyh[43:0];
        s3_next.bhx   = p_bhx[58:0];
        s3_next.bhy   = p_bhy[58:0];
        s3_next.tclip = s2_reg.tclip;
        s3_next.alpha = s2_reg.alpha;
        s3_next.frame = s2_reg.frame;
    end

    // ---------------- stage 4: zoomed extents, top-left corner ----------------
    always_comb
    begin
        corner_t e_uzyw, e_uzxw, e_uzxh, e_uzyh;
        e_uzyw = CW'(s3_reg.uzyw);
        e_uzxw = CW'(s3_reg.uzxw);
        e_uzxh = CW'(s3_reg.uzxh);
        e_uzyh = CW'(s3_reg.uzyh);

        s4_next.px    = s3_reg.px;
        s4_next.py    = s3_reg.py;
        s4_next.sx    = s3_reg.sbx * zoom_reg;
        s4_next.sy    = s3_reg.sby * zoom_reg;
        // width edge is (-uy, ux)*zoom*w, height edge is (ux, uy)*zoom*h*clip
        s4_next.tl_x  = (CW'(s3_reg.px) <<< Q8_SHIFT) + ROUND_HALF
                        + ((e_uzyw - e_uzxh) <<< 15);
        s4_next.tl_y  = (CW'(s3_reg.py) <<< Q8_SHIFT) + ROUND_HALF
                        - ((e_uzxw + e_uzyh) <<< 15);
        s4_next.dw_x  = (-e_uzyw) <<< 16;
        s4_next.dw_y  = e_uzxw <<< 16;
        s4_next.dh_x  = CW'(s3_reg.bhx) <<< 1;
        s4_next.dh_y  = CW'(s3_reg.bhy) <<< 1;
        s4_next.tclip = s3_reg.tclip;
        s4_next.alpha = s3_reg.alpha;
        s4_next.frame = s3_reg.frame;
    end

    // ---------------- stage 5: cull, top-right and bottom-left ----------------
    always_comb
    begin
        logic signed [45:0] cx, cy, ex, ey, lim_l, lim_t, lim_r, lim_b;
        cx    = 46'(s4_reg.px) <<< 12;
        cy    = 46'(s4_reg.py) <<< 12;
        ex    = $signed({2'b00, s4_reg.sx});
        ey    = $signed({2'b00, s4_reg.sy});
        lim_l = 46'(screen_left_reg) <<< 20;
        lim_t = 46'(screen_top_reg) <<< 20;
        lim_r = 46'(screen_right_reg) <<< 20;
        lim_b = 46'(screen_bottom_reg) <<< 20;
        culled = (cx + ex < lim_l) || (cy + ey < lim_t)
                 || (cx - ex > lim_r) || (cy - ey > lim_b);

        s5_next.tl_x  = s4_reg.tl_x;
        s5_next.tl_y  = s4_reg.tl_y;
        s5_next.tr_x  = s4_reg.tl_x + s4_reg.dw_x;
        s5_next.tr_y  = s4_reg.tl_y + s4_reg.dw_y;
        s5_next.bl_x  = s4_reg.tl_x + s4_reg.dh_x;
        s5_next.bl_y  = s4_reg.tl_y + s4_reg.dh_y;
        s5_next.dw_x  = s4_reg.dw_x;
        s5_next.dw_y  = s4_reg.dw_y;
        s5_next.tclip = s4_reg.tclip;
        s5_next.alpha = s4_reg.alpha;
        s5_next.frame = s4_reg.frame;
    end

    // ---------------- stage 6: expander holds all four corners ----------------
    always_comb
    begin
        s6_next.tl_x  = s5_reg.tl_x;
        s6_next.tl_y  = s5_reg.tl_y;
        s6_next.tr_x  = s5_reg.tr_x;
        s6_next.tr_y  = s5_reg.tr_y;
        s6_next.bl_x  = s5_reg.bl_x;
        s6_next.bl_y  = s5_reg.bl_y;
        s6_next.br_x  = s5_reg.bl_x + s5_reg.dw_x;
        s6_next.br_y  = s5_reg.bl_y + s5_reg.dw_y;
        s6_next.tclip = s5_reg.tclip;
        s6_next.alpha = s5_reg.alpha;
        s6_next.frame = s5_reg.frame;
    end

    // ---------------- vertex select and saturation ----------------
    always_comb
    begin
        corner_t sel_x, sel_y;
        case (cnt_reg)
            SLOT_TL0, SLOT_TL1:
            begin
                sel_x             = s6_reg.tl_x;
                sel_y             = s6_reg.tl_y;
                vertex_next.tex_s = 1'b0;
                vertex_next.tex_t = TEX_ONE;
            end
            SLOT_TR:
            begin
                sel_x             = s6_reg.tr_x;
                sel_y             = s6_reg.tr_y;
                vertex_next.tex_s = 1'b1;
                vertex_next.tex_t = TEX_ONE;
            end
            SLOT_BL:
            begin
                sel_x             = s6_reg.bl_x;
                sel_y             = s6_reg.bl_y;
                vertex_next.tex_s = 1'b0;
                vertex_next.tex_t = s6_reg.tclip;
            end
            default:
            begin
                sel_x             = s6_reg.br_x;
                sel_y             = s6_reg.br_y;
                vertex_next.tex_s = 1'b1;
                vertex_next.tex_t = s6_reg.tclip;
            end
        endcase
        vertex_next.vertex_x     = sat_q8(sel_x);
        vertex_next.vertex_y     = sat_q8(sel_y);
        vertex_next.vertex_frame = s6_reg.frame;
        vertex_next.vertex_alpha = s6_reg.alpha;
        vertex_next.last         = (cnt_reg == SLOT_BR1);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
            s1_reg <= s1_next;
        if (rdy2)
            s2_reg <= s2_next;
        if (rdy3)
            s3_reg <= s3_next;
        if (rdy4)
            s4_reg <= s4_next;
        if (rdy5)
            s5_reg <= s5_next;
        if (e_ready)
            s6_reg <= s6_next;
        if (out_load)
            vertex_reg <= vertex_next;
    end

    assign vertex_valid = ov_reg;
    assign vertex       = vertex_reg;

    // ---------------- assertions ----------------
    // a strip is never broken up: after a non-last vertex the next one is ready at once
    a_strip_continuous: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_ready && !vertex.last |=> vertex_valid)
        else $error("vertex strip interrupted");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SLOT_BR1)
        else $error("vertex slot counter out of range");

    // input back-pressure only comes from a full first stage
    a_ready_source: assert property (@(posedge clk) disable iff (!rst_n)
        !sprite_ready |-> v1_reg && !rdy2)
        else $error("sprite channel stalled with room in the pipeline");

    a_last_right_edge: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex.last |-> vertex.tex_s && $past(cnt_reg) == SLOT_BR1
        || vertex_valid && vertex.last && !$past(out_load))
        else $error("last flag on a vertex other than the sixth");

endmodule
